### hw/rtl/qsl_pkg.sv
// Shared types and constants for the quicksort block.
// Depends on nothing; imported by the front end, the queue and the sort engine.
package qsl_pkg;

  localparam int QSL_MAX_ITEMS   = 64;
  localparam int QSL_QUEUE_DEPTH = 4;
  localparam int QSL_VALUE_W     = 16;

  typedef struct packed {
    logic signed [QSL_VALUE_W-1:0] value;
    logic                          last_in;
  } item_t;

  typedef struct packed {
    logic signed [QSL_VALUE_W-1:0] sorted_value;
    logic                          last_out;
    logic                          overflow;
  } result_t;

  typedef enum logic {
    CMD_STORE,
    CMD_DROP
  } cmd_kind_t;

  // One classified item on its way from the front end to the sort engine
  typedef struct packed {
    cmd_kind_t                     kind;
    logic signed [QSL_VALUE_W-1:0] value;
    logic                          last;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_PIV_READ,
    ST_PIV_CAP,
    ST_PART_READ,
    ST_PART_CMP,
    ST_PART_SWAP,
    ST_FIN_READ,
    ST_FIN_W1,
    ST_FIN_W2,
    ST_PUSH_LO,
    ST_PUSH_HI,
    ST_OUT_READ,
    ST_OUT_LOAD
  } sort_state_t;

endpackage

### hw/rtl/qsl_stream_if.sv
// Valid/ready channel carrying one payload struct per transfer.
// Depends on nothing; the payload type is set where the channel is declared.
interface qsl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/qsl_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module qsl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en_a,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic             rd_en_b,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

### hw/rtl/qsl_front.sv
// Input front end: takes items and classifies each as stored or dropped.
// Depends on qsl_pkg and qsl_stream_if.
module qsl_front import qsl_pkg::*; #(
  parameter int MAX_ITEMS = QSL_MAX_ITEMS,
  localparam int CW       = $clog2(MAX_ITEMS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  qsl_stream_if.sink         items,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic          room;

  assign room        = fill < CW'(MAX_ITEMS);
  assign items.ready = cmd_ready;
  assign cmd_valid   = items.valid;
  assign cmd.kind    = room ? CMD_STORE : CMD_DROP;
  assign cmd.value   = items.data.value;
  assign cmd.last    = items.data.last_in;

  always_comb begin
    fill_next = fill;
    if (items.valid && cmd_ready) begin
      if (items.data.last_in) begin
        fill_next = '0;
      end else if (room) begin
        fill_next = fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

### hw/rtl/qsl_queue.sv
// Short command queue between the front end and the sort engine.
// Depends on qsl_pkg.
module qsl_queue import qsl_pkg::*; #(
  parameter int DEPTH = QSL_QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int OW   = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [OW-1:0] occ;
  logic          do_push;
  logic          do_pop;

  assign push_ready = occ != OW'(DEPTH);
  assign pop_valid  = occ != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   occ <= occ + 1'b1;
        2'b01:   occ <= occ - 1'b1;
        default: occ <= occ;
      endcase
    end
  end

endmodule

### hw/rtl/qsl_back.sv
// Sort engine: stores elements, runs Lomuto quicksort over a range stack,
// then streams the sorted set out. Depends on qsl_pkg, qsl_stream_if, qsl_ram.
module qsl_back import qsl_pkg::*; #(
  parameter int MAX_ITEMS = QSL_MAX_ITEMS,
  localparam int IW       = $clog2(MAX_ITEMS),
  localparam int CW       = $clog2(MAX_ITEMS + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  output logic         cmd_ready,
  input  cmd_t         cmd,
  qsl_stream_if.source results
);

  sort_state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] sp, sp_next;
  logic          dropped, dropped_next;
  logic [IW-1:0] lo, lo_next;
  logic [IW-1:0] hi, hi_next;
  logic [IW-1:0] j, j_next;
  logic [IW-1:0] fidx, fidx_next;
  logic [IW-1:0] k, k_next;
  logic signed [QSL_VALUE_W-1:0] pivot, pivot_next;
  logic          out_valid, out_valid_next;
  result_t       out_data, out_data_next;

  logic                   elem_we;
  logic [IW-1:0]          elem_waddr;
  logic [QSL_VALUE_W-1:0] elem_wdata;
  logic                   rda_en, rdb_en;
  logic [IW-1:0]          rda_addr, rdb_addr;
  logic [QSL_VALUE_W-1:0] rda_data, rdb_data;

  logic                   stk_we;
  logic [IW-1:0]          stk_waddr;
  logic [2*IW-1:0]        stk_wdata;
  logic                   stk_re;
  logic [IW-1:0]          stk_raddr;
  logic [2*IW-1:0]        stk_rdata;

  logic [IW-1:0] hi_m1;
  logic [IW-1:0] pop_lo, pop_hi;
  logic          slot_free;
  logic          stk_room;
  logic          is_final;

  qsl_ram #(.WIDTH(QSL_VALUE_W), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk       (clk),
    .wr_en     (elem_we),
    .wr_addr   (elem_waddr),
    .wr_data   (elem_wdata),
    .rd_en_a   (rda_en),
    .rd_addr_a (rda_addr),
    .rd_data_a (rda_data),
    .rd_en_b   (rdb_en),
    .rd_addr_b (rdb_addr),
    .rd_data_b (rdb_data)
  );

  qsl_ram #(.WIDTH(2 * IW), .DEPTH(MAX_ITEMS)) u_stack_ram (
    .clk       (clk),
    .wr_en     (stk_we),
    .wr_addr   (stk_waddr),
    .wr_data   (stk_wdata),
    .rd_en_a   (stk_re),
    .rd_addr_a (stk_raddr),
    .rd_data_a (stk_rdata),
    .rd_en_b   (1'b0),
    .rd_addr_b ('0),
    .rd_data_b ()
  );

  assign hi_m1     = hi - 1'b1;
  assign pop_lo    = stk_rdata[2*IW-1:IW];
  assign pop_hi    = stk_rdata[IW-1:0];
  assign slot_free = !out_valid || results.ready;
  assign stk_room  = sp < CW'(MAX_ITEMS);
  assign is_final  = CW'(k) == (count - 1'b1);

  assign cmd_ready     = state == ST_LOAD;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_comb begin
    state_next     = state;
    count_next     = count;
    sp_next        = sp;
    dropped_next   = dropped;
    lo_next        = lo;
    hi_next        = hi;
    j_next         = j;
    fidx_next      = fidx;
    k_next         = k;
    pivot_next     = pivot;
    out_valid_next = out_valid && !results.ready;
    out_data_next  = out_data;
    elem_we        = 1'b0;
    elem_waddr     = '0;
    elem_wdata     = '0;
    rda_en         = 1'b0;
    rda_addr       = '0;
    rdb_en         = 1'b0;
    rdb_addr       = '0;
    stk_we         = 1'b0;
    stk_waddr      = '0;
    stk_wdata      = '0;
    stk_re         = 1'b0;
    stk_raddr      = '0;

    case (state)
      ST_LOAD: begin
        if (cmd_valid) begin
          if (cmd.kind == CMD_STORE) begin
            elem_we    = 1'b1;
            elem_waddr = count[IW-1:0];
            elem_wdata = cmd.value;
            count_next = count + 1'b1;
          end else begin
            dropped_next = 1'b1;
          end
          if (cmd.last) begin
            state_next = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        k_next = '0;
        if (count < CW'(2)) begin
          state_next = ST_OUT_READ;
        end else begin
          stk_we     = 1'b1;
          stk_waddr  = '0;
          stk_wdata  = {{IW{1'b0}}, IW'(count - 1'b1)};
          sp_next    = CW'(1);
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (sp == '0) begin
          k_next     = '0;
          state_next = ST_OUT_READ;
        end else begin
          stk_re     = 1'b1;
          stk_raddr  = IW'(sp - 1'b1);
          sp_next    = sp - 1'b1;
          state_next = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        lo_next    = pop_lo;
        hi_next    = pop_hi;
        state_next = (pop_lo >= pop_hi) ? ST_POP : ST_PIV_READ;
      end
      ST_PIV_READ: begin
        rda_en     = 1'b1;
        rda_addr   = hi;
        state_next = ST_PIV_CAP;
      end
      ST_PIV_CAP: begin
        pivot_next = $signed(rda_data);
        j_next     = lo;
        fidx_next  = lo;
        state_next = ST_PART_READ;
      end
      ST_PART_READ: begin
        rda_en     = 1'b1;
        rda_addr   = j;
        rdb_en     = 1'b1;
        rdb_addr   = fidx;
        state_next = ST_PART_CMP;
      end
      ST_PART_CMP: begin
        if ($signed(rda_data) < pivot) begin
          // first half of the swap; the front element is held on port b
          elem_we    = 1'b1;
          elem_waddr = fidx;
          elem_wdata = rda_data;
          state_next = ST_PART_SWAP;
        end else if (j == hi_m1) begin
          state_next = ST_FIN_READ;
        end else begin
          // no write this cycle, so the next compare can be fetched at once
          j_next   = j + 1'b1;
          rda_en   = 1'b1;
          rda_addr = j + 1'b1;
          rdb_en   = 1'b1;
          rdb_addr = fidx;
        end
      end
      ST_PART_SWAP: begin
        elem_we    = 1'b1;
        elem_waddr = j;
        elem_wdata = rdb_data;
        fidx_next  = fidx + 1'b1;
        if (j == hi_m1) begin
          state_next = ST_FIN_READ;
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_PART_READ;
        end
      end
      ST_FIN_READ: begin
        rdb_en     = 1'b1;
        rdb_addr   = fidx;
        state_next = ST_FIN_W1;
      end
      ST_FIN_W1: begin
        elem_we    = 1'b1;
        elem_waddr = fidx;
        elem_wdata = pivot;
        state_next = ST_FIN_W2;
      end
      ST_FIN_W2: begin
        elem_we    = 1'b1;
        elem_waddr = hi;
        elem_wdata = rdb_data;
        state_next = ST_PUSH_LO;
      end
      ST_PUSH_LO: begin
        if (({1'b0, fidx} > ({1'b0, lo} + 1'b1)) && stk_room) begin
          stk_we    = 1'b1;
          stk_waddr = sp[IW-1:0];
          stk_wdata = {lo, fidx - 1'b1};
          sp_next   = sp + 1'b1;
        end
        state_next = ST_PUSH_HI;
      end
      ST_PUSH_HI: begin
        if ((({1'b0, fidx} + 1'b1) < {1'b0, hi}) && stk_room) begin
          stk_we    = 1'b1;
          stk_waddr = sp[IW-1:0];
          stk_wdata = {fidx + 1'b1, hi};
          sp_next   = sp + 1'b1;
        end
        state_next = ST_POP;
      end
      ST_OUT_READ: begin
        rda_en     = 1'b1;
        rda_addr   = k;
        state_next = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        if (slot_free) begin
          out_valid_next             = 1'b1;
          out_data_next.sorted_value = $signed(rda_data);
          out_data_next.last_out     = is_final;
          out_data_next.overflow     = dropped;
          if (is_final) begin
            count_next   = '0;
            sp_next      = '0;
            dropped_next = 1'b0;
            state_next   = ST_LOAD;
          end else begin
            k_next     = k + 1'b1;
            state_next = ST_OUT_READ;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      sp        <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      sp        <= sp_next;
      dropped   <= dropped_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo       <= lo_next;
    hi       <= hi_next;
    j        <= j_next;
    fidx     <= fidx_next;
    k        <= k_next;
    pivot    <= pivot_next;
    out_data <= out_data_next;
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(MAX_ITEMS))
    else $error("range stack pointer beyond depth");

  a_part_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PART_CMP || state == ST_PART_SWAP) |-> (fidx <= j && j < hi))
    else $error("partition indices out of order");

  a_load_stack_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (sp == '0))
    else $error("range stack not empty while loading");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_LOAD && slot_free && is_final) |=>
      (state == ST_LOAD && count == '0 && !dropped))
    else $error("set state not cleared after final result");

endmodule

### hw/rtl/quicksort_lomuto.sv
// Quicksort block. Values are taken one per transfer on the items channel and
// stored up to MAX_ITEMS; the item marked last starts the sort. Loading runs at
// one item per cycle through the front end and its queue while the sort engine
// is in its load state; items of the next set queue up during the sort. Sorting
// is quicksort with Lomuto partitioning over a stack of pending ranges, bound by
// the single write port of the element RAM: a compare that leaves an element in
// place fetches the next pair at once, a compare that swaps writes both elements
// in turn, and each range adds a stack pop, pivot fetch, final swap and stack
// pushes. Results then leave one at a time, ascending, with last_out on the
// final one and overflow on every result of a set from which items were dropped.
// A full set of random values takes about 6 compares per element; an already
// ordered set falls to the quadratic worst case.
// Depends on qsl_pkg, qsl_stream_if, qsl_front, qsl_queue and qsl_back.
module quicksort_lomuto import qsl_pkg::*; #(
  parameter int MAX_ITEMS   = QSL_MAX_ITEMS,
  parameter int QUEUE_DEPTH = QSL_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  qsl_stream_if.sink   items,
  qsl_stream_if.source results
);

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  qsl_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  qsl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  qsl_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .results   (results)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for quicksort_lomuto: sets of signed values go in, ascending runs come out.
// Depends on qsl_pkg, qsl_stream_if and the quicksort_lomuto RTL.
module tb_top;
  import qsl_pkg::*;

  localparam int CAPACITY     = QSL_MAX_ITEMS;
  localparam int RANDOM_ITEMS = 260;
  localparam int HOLD_AFTER   = 17;      // first result after the directed sets
  localparam int LONG_HOLD    = 1500;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum {
    SHAPE_RANDOM,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_FEW
  } set_shape_t;

  typedef struct {
    item_t item;
    bit    wait_drain;
  } pending_t;

  logic clk;
  logic rst;

  qsl_stream_if #(.payload_t(item_t))   items_ch ();
  qsl_stream_if #(.payload_t(result_t)) results_ch ();

  quicksort_lomuto #(.MAX_ITEMS(CAPACITY)) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  // predictor state
  logic signed [QSL_VALUE_W-1:0] held_vals [CAPACITY];
  int unsigned                   held_count = 0;
  bit                            lost_any = 1'b0;
  result_t                       sorted_due [$];

  pending_t    send_q [$];
  pending_t    next_item;
  int unsigned sent_count = 0;
  int unsigned got_results = 0;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned pick_gap(int unsigned phase_count);
    int unsigned roll;
    // every third stretch of 40 transfers runs flat out
    if ((phase_count / 40) % 3 == 2) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lomuto quicksort of the held set, pending ranges kept on a stack
  function automatic void quicksort_held(int n);
    int lo_stack [$];
    int hi_stack [$];
    int lo;
    int hi;
    int front;
    logic signed [QSL_VALUE_W-1:0] pivot;
    logic signed [QSL_VALUE_W-1:0] tmp;
    if (n < 2) return;
    lo_stack.push_back(0);
    hi_stack.push_back(n - 1);
    while (lo_stack.size() > 0) begin
      lo = lo_stack.pop_back();
      hi = hi_stack.pop_back();
      if (lo >= hi) continue;
      pivot = held_vals[hi];
      front = lo;
      for (int j = lo; j < hi; j++) begin
        if (held_vals[j] < pivot) begin
          tmp = held_vals[front];
          held_vals[front] = held_vals[j];
          held_vals[j] = tmp;
          front++;
        end
      end
      tmp = held_vals[front];
      held_vals[front] = held_vals[hi];
      held_vals[hi] = tmp;
      if (front > lo + 1) begin
        lo_stack.push_back(lo);
        hi_stack.push_back(front - 1);
      end
      if (front + 1 < hi) begin
        lo_stack.push_back(front + 1);
        hi_stack.push_back(hi);
      end
    end
  endfunction

  function automatic void absorb_value(item_t it);
    result_t r;
    if (held_count < CAPACITY) begin
      held_vals[held_count] = it.value;
      held_count++;
    end else begin
      lost_any = 1'b1;
    end
    if (!it.last_in) return;
    quicksort_held(held_count);
    for (int k = 0; k < held_count; k++) begin
      r.sorted_value = held_vals[k];
      r.last_out     = (k == held_count - 1);
      r.overflow     = lost_any;
      sorted_due.push_back(r);
    end
    held_count = 0;
    lost_any   = 1'b0;
  endfunction

  function automatic void push_item(logic signed [QSL_VALUE_W-1:0] v, bit last, bit drain);
    pending_t p;
    p.item.value   = v;
    p.item.last_in = last;
    p.wait_drain   = drain;
    send_q.push_back(p);
  endfunction

  function automatic logic signed [QSL_VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return -16'sd32768;
    if (roll < 8) return 16'sd32767;
    if (roll < 10) return '0;
    if (roll < 12) return -16'sd1;
    return QSL_VALUE_W'($urandom_range(0, 65535));
  endfunction

  function automatic void queue_set(int n, set_shape_t shape, bit drain);
    int base;
    int v;
    base = $urandom_range(0, 100);
    for (int k = 0; k < n; k++) begin
      case (shape)
        SHAPE_RISING:  v = -32768 + base + k * 500;
        SHAPE_FALLING: v = 32767 - base - k * 500;
        SHAPE_FEW:     v = $urandom_range(0, 3) - 1;
        default:       v = pick_value();
      endcase
      push_item(v[QSL_VALUE_W-1:0], k == n - 1, drain && k == 0);
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      items_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (items_ch.valid && items_ch.ready) begin
        absorb_value(items_ch.data);
        sent_count++;
      end
      if (!(items_ch.valid && !items_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          items_ch.valid <= 1'b0;
        end else if (send_q.size() > 0 &&
                     !(send_q[0].wait_drain && sorted_due.size() > 0)) begin
          next_item = send_q.pop_front();
          items_ch.valid <= 1'b1;
          items_ch.data  <= next_item.item;
          gap_left = pick_gap(sent_count);
        end else begin
          items_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (rst) begin
      results_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        seen = results_ch.data;
        got_results++;
        if (sorted_due.size() == 0) begin
          $error("unexpected result: sorted_value %0d last_out %0b overflow %0b",
                 seen.sorted_value, seen.last_out, seen.overflow);
          mismatch_count++;
        end else begin
          want = sorted_due.pop_front();
          if (seen.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value, seen.sorted_value);
            mismatch_count++;
          end
          if (seen.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, seen.last_out);
            mismatch_count++;
          end
          if (seen.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, seen.overflow);
            mismatch_count++;
          end
        end
        // long back-pressure so the input side fills up and stalls
        if (got_results == HOLD_AFTER) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
        stall_left = pick_gap(got_results + 20);
      end
    end
  end

  initial begin
    int total;
    int set_idx;
    int n;
    rst = 1'b1;

    // single-element sets at both extremes, then a pair in reverse order
    push_item(-16'sd32768, 1'b1, 1'b0);
    push_item(16'sd32767, 1'b1, 1'b0);
    push_item(16'sd32767, 1'b0, 1'b0);
    push_item(-16'sd32768, 1'b1, 1'b0);
    // equal values
    push_item(16'sd7, 1'b0, 1'b0);
    push_item(16'sd7, 1'b0, 1'b0);
    push_item(-16'sd3, 1'b0, 1'b0);
    push_item(16'sd7, 1'b0, 1'b0);
    push_item(16'sd7, 1'b1, 1'b0);
    // bit patterns and extremes in one set
    push_item(16'sd0, 1'b0, 1'b0);
    push_item(-16'sd1, 1'b0, 1'b0);
    push_item(16'sh5555, 1'b0, 1'b0);
    push_item(16'shAAAA, 1'b0, 1'b0);
    push_item(16'sd1, 1'b0, 1'b0);
    push_item(-16'sd32768, 1'b0, 1'b0);
    push_item(16'sd32767, 1'b1, 1'b0);

    total   = 0;
    set_idx = 0;
    while (total < RANDOM_ITEMS) begin
      case (set_idx)
        3:  begin n = CAPACITY;     queue_set(n, SHAPE_RISING, 1'b0);  end
        7:  begin n = CAPACITY + 1; queue_set(n, SHAPE_RANDOM, 1'b0);  end // last one dropped
        11: begin n = CAPACITY + 2; queue_set(n, SHAPE_FALLING, 1'b1); end
        default: begin
          n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 16);
          // first random set waits for the directed results to drain
          queue_set(n, ($urandom_range(0, 4) == 0) ? SHAPE_FEW : SHAPE_RANDOM,
                    set_idx % 10 == 0);
        end
      endcase
      total += n;
      set_idx++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (send_q.size() > 0 || items_ch.valid || sorted_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
